/* hw/rtl/sha512_hash_engine_unit_defines.svh */
// assertion macros used by the hash engine rtl
// depends on nothing; included by files that carry assertions
`ifndef SHA512_HASH_ENGINE_UNIT_DEFINES_SVH
`define SHA512_HASH_ENGINE_UNIT_DEFINES_SVH
// check that a condition implies another in the same cycle
`define SHE_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// check that a condition implies another in the next cycle
`define SHE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

/* hw/rtl/she_pkg.sv */
// types, constants and round functions for the sha-512 engine
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package she_pkg;
	typedef struct packed {
		logic [63:0]  data;
		logic [3:0]   bytes;
		logic         eom;
	} req_t;

	localparam int QDEPTH = 4;

	localparam logic [63:0] IV512 [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
	localparam logic [63:0] IV384 [8] = '{
		64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
		64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
		64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

	localparam logic [63:0] ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/she_front.sv */
// front end: takes requests into a short queue for the compression core
// depends on she_pkg
`timescale 1ns / 1ps
`default_nettype none
module she_front import she_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        end_of_message,
	output logic             q_valid,
	output req_t             q_req,
	input  wire logic        q_take
);
	localparam int AW = $clog2(QDEPTH);
	req_t mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;
	req_t in_req;

	// classify the word: a non-final word always counts full bytes
	always_comb begin
		in_req.data = data_word;
		in_req.eom = end_of_message;
		if (!end_of_message || byte_count > 4'd8) in_req.bytes = 4'd8;
		else in_req.bytes = byte_count;
	end

	assign full = (cnt_q == (AW+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_req = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = q_take && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= in_req;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/she_core.sv */
// back end: block assembly, padding, 80-round compression, digest output
// depends on she_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sha512_hash_engine_unit_defines.svh"
module she_core import she_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        iv_sel,
	input  wire logic        iv_load,
	input  wire logic        q_valid,
	input  req_t             q_req,
	output logic             q_take,
	output logic             idle,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	localparam logic [2:0] ST_FILL = 3'd0, ST_PAD = 3'd1, ST_RUN = 3'd2,
		ST_ADD = 3'd3, ST_OUT = 3'd4;
	logic [2:0] st_q;
	logic [63:0] h_q [8];
	logic [63:0] v_q [8];
	logic [63:0] w_q [16];
	logic [127:0] total_q;
	logic [3:0] wf_q;
	logic [6:0] rnd_q;
	logic fin_q;         // separate padding-byte word still owed
	logic len_q;         // length words still owed
	logic [1:0] lenph_q; // 1: high length word placed, 2: length complete
	logic [2:0] oi_q;
	logic [63:0] wnew, wt, t1, t2, pad_word, put_val;
	logic put;
	logic [3:0] b;
	logic [5:0] sh;
	logic [63:0] x2, x15;

	// message schedule next word
	always_comb begin
		x2 = w_q[4'(rnd_q - 7'd2)];
		x15 = w_q[4'(rnd_q - 7'd15)];
		wnew = w_q[rnd_q[3:0]] + (rotr(x2,19) ^ rotr(x2,61) ^ (x2 >> 6))
			+ w_q[4'(rnd_q - 7'd7)] + (rotr(x15,1) ^ rotr(x15,8) ^ (x15 >> 7));
		wt = (rnd_q < 7'd16) ? w_q[rnd_q[3:0]] : wnew;
		t1 = v_q[7] + (rotr(v_q[4],14) ^ rotr(v_q[4],18) ^ rotr(v_q[4],41))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + wt;
		t2 = (rotr(v_q[0],28) ^ rotr(v_q[0],34) ^ rotr(v_q[0],39))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// final word with padding byte
	always_comb begin
		b = q_req.bytes;
		sh = 6'(7'd64 - {b, 3'b000});
		if (b == 4'd8) pad_word = q_req.data;
		else if (b == 4'd0) pad_word = 64'h80 << 56;
		else pad_word = ((q_req.data >> sh) << sh) | (64'h80 << (sh - 6'd8));
	end

	// word placement into the block
	always_comb begin
		put = 1'b0; put_val = '0; q_take = 1'b0;
		case (st_q)
			ST_FILL: begin
				if (q_valid) begin
					q_take = 1'b1; put = 1'b1;
					put_val = q_req.eom ? pad_word : q_req.data;
				end
			end
			ST_PAD: begin
				put = 1'b1;
				if (fin_q) put_val = 64'h80 << 56;
				else if (len_q && wf_q == 4'd14)
					put_val = {total_q[124:64], total_q[63:61]};
				else if (lenph_q == 2'd1 && wf_q == 4'd15)
					put_val = {total_q[60:0], 3'b000};
				else put_val = '0;
			end
			default: ;
		endcase
	end

	assign idle = (st_q == ST_FILL) && !q_valid && total_q == '0 && wf_q == '0;
	assign empty = (st_q != ST_OUT);
	assign digest_word = h_q[oi_q];
	assign word_index = oi_q;
	assign last_word = (oi_q == 3'd7);

	always_ff @(posedge clk) begin
		if (put) w_q[wf_q] <= put_val;
		if (st_q == ST_RUN) begin
			if (rnd_q >= 7'd16) w_q[rnd_q[3:0]] <= wnew;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1; v_q[3] <= v_q[2]; v_q[2] <= v_q[1];
			v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
		end
		if (put && wf_q == 4'd15) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_FILL; total_q <= '0; wf_q <= '0; rnd_q <= '0;
			fin_q <= 1'b0; len_q <= 1'b0; lenph_q <= '0; oi_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= IV512[i];
		end else begin
			if (iv_load)
				for (int i = 0; i < 8; i++) h_q[i] <= iv_sel ? IV512[i] : IV384[i];
			if (put) wf_q <= wf_q + 4'd1;
			case (st_q)
				ST_FILL: if (q_valid) begin
					total_q <= total_q + 128'(q_req.bytes);
					if (q_req.eom) begin
						fin_q <= (q_req.bytes == 4'd8);
						len_q <= 1'b1;
					end
					if (wf_q == 4'd15) st_q <= ST_RUN;
					else if (q_req.eom) st_q <= ST_PAD;
				end
				ST_PAD: begin
					fin_q <= 1'b0;
					// the length goes in only when both of its words fit
					if (!fin_q && len_q && wf_q == 4'd14) lenph_q <= 2'd1;
					if (wf_q == 4'd15) begin
						st_q <= ST_RUN;
						if (lenph_q == 2'd1) begin
							len_q <= 1'b0;
							lenph_q <= 2'd2;
						end
					end
				end
				ST_RUN: begin
					if (rnd_q == 7'd79) begin
						rnd_q <= '0;
						st_q <= ST_ADD;
					end else rnd_q <= rnd_q + 7'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					// an extra block when the length did not fit
					if (len_q) st_q <= ST_PAD;
					else if (lenph_q == 2'd2) st_q <= ST_OUT;
					else st_q <= ST_FILL;
				end
				ST_OUT: if (pop) begin
					oi_q <= oi_q + 3'd1;
					if (oi_q == 3'd7) begin
						st_q <= ST_FILL; total_q <= '0; wf_q <= '0;
						lenph_q <= '0;
						for (int i = 0; i < 8; i++)
							h_q[i] <= iv_sel ? IV512[i] : IV384[i];
					end
				end
				default: st_q <= ST_FILL;
			endcase
		end
	end

	`SHE_ASSERT_IMP(a_take_fill, clk, arst_n, q_take, st_q == ST_FILL)
	`SHE_ASSERT_IMP(a_out_empty, clk, arst_n, st_q == ST_OUT, !empty)
	`SHE_ASSERT_NEXT(a_round_wrap, clk, arst_n, st_q == ST_RUN && rnd_q == 7'd79,
		st_q == ST_ADD)
endmodule
`default_nettype wire

/* hw/rtl/sha512_hash_engine_unit.sv */
// top level of the sha-512/384 engine: config port, front queue, core
// depends on she_pkg, she_front, she_core
//
// channel   handshake        payload
// input     push / full      data_word, byte_count, end_of_message
// result    pop / empty      digest_word, word_index, last_word
// config    apb write        iv_select at address 0
//
// a 16-word block is filled word by word, compressed one round at a time
// in the single round unit and added in; no word is taken meanwhile.
// a final word adds padding fill cycles, possibly a second block, and 8 pops.
// reset loads the sha-512 initial values; the input queue holds 4 requests.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_engine_unit import she_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        end_of_message,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic iv_q, q_valid, q_take, idle, wr;
	req_t q_req;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && (paddr == 2'd0);
	assign prdata = (paddr == 2'd0) ? {31'd0, iv_q} : 32'd0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) iv_q <= 1'b1;
		else if (wr) iv_q <= pwdata[0];
	end

	she_front u_front (.clk, .arst_n, .push, .full, .data_word, .byte_count,
		.end_of_message, .q_valid, .q_req, .q_take);

	she_core u_core (.clk, .arst_n, .iv_sel(wr ? pwdata[0] : iv_q),
		.iv_load(wr && idle), .q_valid, .q_req, .q_take, .idle, .empty, .pop,
		.digest_word, .word_index, .last_word);
endmodule
`default_nettype wire

/* tb/sha512_digest_checker.sv */
// digest checker for the sha-512/384 engine: watches the request and digest
// channels, predicts digests in software and compares them field by field
// depends on she_pkg (initial values and round constants)
`timescale 1ns / 1ps
module sha512_digest_checker import she_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        end_of_message,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	input  logic        cfg_write,
	input  logic        cfg_sel_512,
	output int          fail_count,
	output int          digests_pending
);
	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	// predictor state
	logic        use_512;
	logic [63:0] hash_state [8];
	logic [63:0] block_buf [16];
	logic [127:0] msg_bytes;
	int          fill_level;
	digest_t     digest_queue [$];

	function automatic logic [63:0] ror(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			hash_state[i] = use_512 ? IV512[i] : IV384[i];
		msg_bytes = '0;
		fill_level = 0;
	endtask

	task automatic compress_block();
		logic [63:0] w [80];
		logic [63:0] v [8];
		logic [63:0] t1, t2;
		for (int t = 0; t < 80; t++) begin
			if (t < 16)
				w[t] = block_buf[t];
			else
				w[t] = (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
					+ (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int t = 0; t < 80; t++) begin
			t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic append_word(input logic [63:0] w);
		block_buf[fill_level] = w;
		fill_level++;
		if (fill_level == 16) begin
			compress_block();
			fill_level = 0;
		end
	endtask

	task automatic absorb_request(input logic [63:0] d, input logic [3:0] nb, input logic eom);
		int          n;
		int          sh;
		logic [63:0] kept;
		logic [127:0] bits;
		digest_t     e;
		if (!eom) begin
			msg_bytes += 8;
			append_word(d);
		end else begin
			n = (nb > 8) ? 8 : int'(nb);
			msg_bytes += n;
			if (n == 8) begin
				append_word(d);
				append_word(64'h80 << 56);
			end else begin
				sh = 64 - 8 * n;
				kept = (n == 0) ? 64'd0 : ((d >> sh) << sh);
				append_word(kept | (64'h80 << (sh - 8)));
			end
			if (fill_level > 14)
				while (fill_level != 0)
					append_word(64'd0);
			while (fill_level < 14)
				append_word(64'd0);
			bits = msg_bytes << 3;
			append_word(bits[127:64]);
			append_word(bits[63:0]);
			for (int i = 0; i < 8; i++) begin
				e.word = hash_state[i];
				e.idx = 3'(i);
				e.last = (i == 7);
				digest_queue.push_back(e);
			end
			restart_message();
		end
	endtask

	// observe both channels and config writes at the rising edge
	always @(posedge clk or negedge arst_n) begin
		digest_t e;
		if (!arst_n) begin
			use_512 = 1'b1;
			restart_message();
			digest_queue.delete();
			fail_count = 0;
			digests_pending = 0;
		end else begin
			if (cfg_write) begin
				use_512 = cfg_sel_512;
				if (msg_bytes == 0 && fill_level == 0)
					restart_message();
			end
			if (pop && !empty) begin
				if (digest_queue.size() == 0) begin
					$error("digest word with no request pending: %h", digest_word);
					fail_count++;
				end else begin
					e = digest_queue.pop_front();
					if (digest_word !== e.word) begin
						$error("digest_word expected %h actual %h", e.word, digest_word);
						fail_count++;
					end
					if (word_index !== e.idx) begin
						$error("word_index expected %0d actual %0d", e.idx, word_index);
						fail_count++;
					end
					if (last_word !== e.last) begin
						$error("last_word expected %0b actual %0b", e.last, last_word);
						fail_count++;
					end
				end
			end
			if (push && !full)
				absorb_request(data_word, byte_count, end_of_message);
			digests_pending = digest_queue.size();
		end
	end
endmodule

/* tb/tb_sha512_hash_engine_unit.sv */
// stimulus and verdict for the sha-512/384 engine: directed and random
// messages under varied idle patterns, apb writes to iv_select between phases
// depends on she_pkg, sha512_hash_engine_unit and sha512_digest_checker
`timescale 1ns / 1ps
module tb_sha512_hash_engine_unit;
	import she_pkg::*;

	localparam logic [1:0] ADDR_IV_SELECT = 2'd0;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        end_of_message;
	logic        empty;
	logic        pop;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          digests_pending;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off;
	int          cycle_count;

	sha512_hash_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_word(data_word), .byte_count(byte_count), .end_of_message(end_of_message),
		.empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
		.last_word(last_word), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sha512_digest_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_word(data_word), .byte_count(byte_count), .end_of_message(end_of_message),
		.empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
		.last_word(last_word),
		.cfg_write(psel && penable && pwrite && pready && paddr == ADDR_IV_SELECT),
		.cfg_sel_512(pwdata[0]), .fail_count(fail_count), .digests_pending(digests_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// digest receiver: random stalls, plus a long hold-off on request
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				pop <= 1'b0;
			end else
				pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// send one request, waiting for acceptance; push stays high for the next one
	task automatic send_request(input logic [63:0] d, input logic [3:0] nb, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_word <= d;
		byte_count <= nb;
		end_of_message <= eom;
		// full only changes at the rising edge, so it is stable here
		while (full)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(input int words, input logic [3:0] last_nb);
		for (int i = 0; i < words - 1; i++)
			send_request({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
		send_request({$urandom, $urandom}, last_nb, 1'b1);
	endtask

	// stop sending, wait until every digest has arrived, then let the core settle
	task automatic drain();
		push <= 1'b0;
		while (digests_pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_iv_select(input logic sel_512);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_IV_SELECT;
		pwdata <= {$urandom} & 32'hffff_fffe | sel_512;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(input int n_msgs);
		int words;
		for (int m = 0; m < n_msgs; m++) begin
			// mostly short messages, sometimes near the block boundary
			if ($urandom_range(3) == 0)
				words = $urandom_range(13, 18);
			else
				words = $urandom_range(1, 6);
			send_message(words, 4'($urandom_range(15)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_word = '0;
		byte_count = '0;
		end_of_message = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty final word, full final, field extremes, padding edges
		send_request(64'd0, 4'd0, 1'b1);
		send_request(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
		send_request(64'h6162_6300_0000_0000, 4'd3, 1'b1);
		send_request(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
		send_request(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1);
		send_request(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
		send_request(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
		send_message(14, 4'd8);
		send_message(15, 4'd0);
		send_message(16, 4'd5);
		drain();
		write_iv_select(1'b0);
		send_message(1, 4'd9);
		send_message(13, 4'd8);
		drain();
		write_iv_select(1'b1);

		// random phases with differing idle patterns
		random_phase(8);
		drain();
		write_iv_select(1'b0);
		send_idle_pct = 77;
		random_phase(8);
		drain();
		write_iv_select(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		random_phase(8);
		drain();
		send_idle_pct = 25;
		recv_stall_pct = 25;
		random_phase(8);

		// receiver holds off while messages keep arriving
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 3000;
		random_phase(6);
		drain();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
